// File: hdl/oal_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oal_pkg
// Shared constants and types of the ordered array list: sizes, operation
// codes and the command word that is broadcast to every cell of the chain.
// ----------------------------------------------------------------------------
package oal_pkg;

    localparam int DEPTH    = 64;
    localparam int MODE_W   = 2;
    localparam int POS_W    = 7;
    localparam int VAL_W    = 16;
    localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    // compare width, roomy enough for count + 1 and for any position
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // first-match search: groups of GRP_SIZE cells, one register level per group
    localparam int GRP_SIZE = 8;
    localparam int GRP_W    = $clog2(GRP_SIZE);
    localparam int NGRP     = (DEPTH + GRP_SIZE - 1) / GRP_SIZE;
    localparam int NGRP_W   = (NGRP > 1) ? $clog2(NGRP) : 1;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOCATE = 2'd2;

    typedef struct packed {
        logic                    ins;    // shift up from pos, load value at pos
        logic                    del;    // shift down from pos
        logic [IDX_W-1:0]        pos;    // 0-based position
        logic [CMP_W-1:0]        count;  // entries held before the operation
        logic signed [VAL_W-1:0] value;
    } t_bcast;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
    } t_find;

endpackage
`default_nettype wire

// File: hdl/oal_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oal_cell
// One list slot: holds an entry, takes its left neighbor's entry or the new
// value on insert, its right neighbor's on delete, and flags a search match.
// ----------------------------------------------------------------------------
module oal_cell (
    input  wire logic                            i_clk,
    input  wire logic [oal_pkg::IDX_W-1:0]       i_idx,
    input  wire oal_pkg::t_bcast                 i_cmd,
    input  wire logic signed [oal_pkg::VAL_W-1:0] i_left,
    input  wire logic signed [oal_pkg::VAL_W-1:0] i_right,
    output logic signed [oal_pkg::VAL_W-1:0]     o_entry,
    output logic                                 o_match
);
    import oal_pkg::*;

    logic signed [VAL_W-1:0] r_entry;
    logic signed [VAL_W-1:0] n_entry;
    logic                    r_match;
    logic                    n_match;

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.ins) begin
            if (i_idx > i_cmd.pos) begin
                n_entry = i_left;
            end else if (i_idx == i_cmd.pos) begin
                n_entry = i_cmd.value;
            end
        end else if (i_cmd.del) begin
            if (i_idx >= i_cmd.pos) begin
                n_entry = i_right;
            end
        end
        // only held entries take part in the search
        n_match = (r_entry == i_cmd.value) && (CMP_W'(i_idx) < i_cmd.count);
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_match <= n_match;
    end

    assign o_entry = r_entry;
    assign o_match = r_match;

endmodule
`default_nettype wire

// File: hdl/oal_find.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oal_find
// First-match search over the cell match flags: a registered per-group
// priority encode, then a priority pick across the groups.
// ----------------------------------------------------------------------------
module oal_find (
    input  wire logic                      i_clk,
    input  wire logic [oal_pkg::DEPTH-1:0] i_match,
    output oal_pkg::t_find                 o_find
);
    import oal_pkg::*;

    logic [NGRP*GRP_SIZE-1:0] w_pad;
    logic [NGRP-1:0]          r_hit;
    logic [NGRP-1:0]          n_hit;
    logic [GRP_W-1:0]         r_low [NGRP];
    logic [GRP_W-1:0]         n_low [NGRP];
    logic [NGRP_W-1:0]        w_grp;
    logic                     w_any;

    always_comb begin
        w_pad = '0;
        w_pad[DEPTH-1:0] = i_match;
        for (int g = 0; g < NGRP; g++) begin
            n_hit[g] = |w_pad[g*GRP_SIZE +: GRP_SIZE];
            n_low[g] = '0;
            for (int k = GRP_SIZE - 1; k >= 0; k--) begin
                if (w_pad[g*GRP_SIZE + k]) begin
                    n_low[g] = GRP_W'(k);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit <= n_hit;
        r_low <= n_low;
    end

    always_comb begin
        w_grp = '0;
        w_any = 1'b0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (r_hit[g]) begin
                w_grp = NGRP_W'(g);
                w_any = 1'b1;
            end
        end
        o_find.hit = w_any;
        o_find.idx = IDX_W'({w_grp, r_low[w_grp]});
    end

endmodule
`default_nettype wire

// File: hdl/ordered_array_list.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_array_list
// Bounded positional list of signed 16-bit entries kept in a chain of cells.
// ----------------------------------------------------------------------------
// Input channel i_valid/o_ready carries one operation word: i_mode (insert,
// delete, locate), a 1-based i_position and i_value. Output channel
// o_valid/i_ready returns one result word per operation: o_ok, o_found_at
// (first matching position on locate, else 0) and o_count_now.
// Each accepted operation is registered, then passes a step in which every cell
// shifts or compares at once, the per-group match encode and the pick across
// groups that loads the output register. One word is in flight at a time:
// no new word is taken until the current one has loaded the output register.
// Reset empties the list (count zero); entry storage is not cleared and is
// never read before written.
// When the receiver stalls the result holds in the output register and the
// next operation waits in its last step until the register frees up.
// ----------------------------------------------------------------------------
module ordered_array_list (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic [oal_pkg::MODE_W-1:0]        i_mode,
    input  wire logic [oal_pkg::POS_W-1:0]         i_position,
    input  wire logic signed [oal_pkg::VAL_W-1:0]  i_value,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic                                   o_ok,
    output logic [oal_pkg::POS_W-1:0]              o_found_at,
    output logic [oal_pkg::POS_W-1:0]              o_count_now
);
    import oal_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_GRP  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]              r_state;
    logic [1:0]              n_state;
    logic [MODE_W-1:0]       r_mode;
    logic [POS_W-1:0]        r_position;
    logic signed [VAL_W-1:0] r_value;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic                    r_ok;
    logic                    r_out_valid;
    logic                    r_out_ok;
    logic [POS_W-1:0]        r_out_found_at;
    logic [POS_W-1:0]        r_out_count_now;

    logic [CMP_W-1:0]        w_pos;
    logic [CMP_W-1:0]        w_cnt;
    logic                    w_ins_ok;
    logic                    w_del_ok;
    logic                    w_out_free;
    logic                    w_done;
    t_bcast                  w_cmd;
    t_find                   w_find;
    logic signed [VAL_W-1:0] w_entry [DEPTH];
    logic [DEPTH-1:0]        w_match;

    assign w_pos      = CMP_W'(r_position);
    assign w_cnt      = CMP_W'(r_count);
    assign w_ins_ok   = (r_mode == MODE_INSERT) && (w_pos != '0)
                        && (w_pos <= w_cnt + CMP_W'(1)) && (w_cnt < CMP_W'(DEPTH));
    assign w_del_ok   = (r_mode == MODE_DELETE) && (w_pos != '0) && (w_pos <= w_cnt);
    assign w_out_free = !r_out_valid || i_ready;
    assign w_done     = (r_state == S_FIN) && w_out_free;

    always_comb begin
        w_cmd.ins   = (r_state == S_EXEC) && w_ins_ok;
        w_cmd.del   = (r_state == S_EXEC) && w_del_ok;
        w_cmd.pos   = IDX_W'(w_pos - CMP_W'(1));
        w_cmd.count = w_cnt;
        w_cmd.value = r_value;
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic signed [VAL_W-1:0] w_left;
            logic signed [VAL_W-1:0] w_right;
            if (gi == 0) begin : g_first
                assign w_left = r_value;
            end else begin : g_mid_l
                assign w_left = w_entry[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_last
                assign w_right = w_entry[gi];
            end else begin : g_mid_r
                assign w_right = w_entry[gi+1];
            end
            oal_cell u_cell (
                .i_clk   (i_clk),
                .i_idx   (IDX_W'(gi)),
                .i_cmd   (w_cmd),
                .i_left  (w_left),
                .i_right (w_right),
                .o_entry (w_entry[gi]),
                .o_match (w_match[gi])
            );
        end
    endgenerate

    oal_find u_find (
        .i_clk   (i_clk),
        .i_match (w_match),
        .o_find  (w_find)
    );

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_GRP;
                if (w_ins_ok) begin
                    n_count = r_count + CNT_W'(1);
                end else if (w_del_ok) begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            S_GRP: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_mode     <= i_mode;
            r_position <= i_position;
            r_value    <= i_value;
        end
        if (r_state == S_EXEC) begin
            r_ok <= w_ins_ok || w_del_ok;
        end
        if (w_done) begin
            r_out_count_now <= POS_W'(r_count);
            if (r_mode == MODE_LOCATE) begin
                r_out_ok       <= w_find.hit;
                r_out_found_at <= w_find.hit ? POS_W'(CNT_W'(w_find.idx) + CNT_W'(1)) : '0;
            end else begin
                r_out_ok       <= r_ok;
                r_out_found_at <= '0;
            end
        end
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_ok        = r_out_ok;
    assign o_found_at  = r_out_found_at;
    assign o_count_now = r_out_count_now;

endmodule
`default_nettype wire

// File: hdl/oal_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oal_check
// Port-level checks of the ordered array list, bound to the top level.
// ----------------------------------------------------------------------------
module oal_check (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    input  wire logic                              o_ready,
    input  wire logic                              o_valid,
    input  wire logic                              i_ready,
    input  wire logic                              o_ok,
    input  wire logic [oal_pkg::POS_W-1:0]         o_found_at,
    input  wire logic [oal_pkg::POS_W-1:0]         o_count_now
);
    import oal_pkg::*;

    // a found position implies success and lies within the list
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found_at != '0) |-> (o_ok && o_found_at <= o_count_now))
        else $error("found position without success or beyond count");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_count_now <= POS_W'(DEPTH)))
        else $error("count beyond list depth");

    // one word in flight: no new word right after an accepted one
    a_one_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second word taken while one is in flight");

    // count only moves by a successful insert or delete
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready) ##1 o_valid && !$stable(o_count_now) |-> o_ok)
        else $error("count changed on a failed operation");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_ok) && $stable(o_found_at)
                                   && $stable(o_count_now)))
        else $error("stalled result changed");

endmodule

bind ordered_array_list oal_check u_oal_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_ok        (o_ok),
    .o_found_at  (o_found_at),
    .o_count_now (o_count_now)
);
`default_nettype wire

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ordered array list: insert, delete, locate and
// unused-mode words go in under random gaps, a shadow list copy predicts each
// result word, and result words are compared in order under random stalls.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import oal_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int TARGET_WORDS = 550;

    typedef struct {
        logic [MODE_W-1:0]       mode;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
        int                      gap;
        bit                      drain_first;
    } t_list_op;

    typedef struct {
        logic             ok;
        logic [POS_W-1:0] found_at;
        logic [POS_W-1:0] count_now;
    } t_list_result;

    logic                    i_clk      = 1'b0;
    logic                    i_rst_n    = 1'b0;
    logic                    i_valid    = 1'b0;
    logic [MODE_W-1:0]       i_mode     = '0;
    logic [POS_W-1:0]        i_position = '0;
    logic signed [VAL_W-1:0] i_value    = '0;
    logic                    i_ready    = 1'b0;
    logic                    o_ready;
    logic                    o_valid;
    logic                    o_ok;
    logic [POS_W-1:0]        o_found_at;
    logic [POS_W-1:0]        o_count_now;

    ordered_array_list dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_mode      (i_mode),
        .i_position  (i_position),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_ok        (o_ok),
        .o_found_at  (o_found_at),
        .o_count_now (o_count_now)
    );

    always #5 i_clk = ~i_clk;

    t_list_op     ops_to_send[$];
    t_list_result list_results_due[$];
    t_list_op     op_on_bus;

    // shadow list used for prediction
    logic signed [VAL_W-1:0] list_vals [DEPTH];
    int list_len = 0;

    // generator side bookkeeping
    int gen_len    = 0;
    int gen_words  = 0;
    bit quiet_round = 1'b0;

    int errors = 0;
    int words_sent = 0;
    int words_checked = 0;
    int ins_ok = 0, ins_rej = 0, full_rej = 0, del_ok = 0, del_rej = 0;
    int loc_hit = 0, loc_miss = 0, unused_words = 0, peak_len = 0;

    task automatic flag_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        errors++;
    endtask

    function automatic t_list_result apply_list_op(input t_list_op w);
        t_list_result r;
        int p;
        int k;
        r.ok = 1'b0;
        r.found_at = '0;
        p = int'(w.position);
        case (w.mode)
            MODE_INSERT: begin
                if (p >= 1 && p <= list_len + 1 && list_len < DEPTH) begin
                    for (k = list_len; k >= p; k--) list_vals[k] = list_vals[k-1];
                    list_vals[p-1] = w.value;
                    list_len++;
                    r.ok = 1'b1;
                    ins_ok++;
                end else begin
                    ins_rej++;
                    if (list_len == DEPTH) full_rej++;
                end
            end
            MODE_DELETE: begin
                if (p >= 1 && p <= list_len) begin
                    for (k = p; k < list_len; k++) list_vals[k-1] = list_vals[k];
                    list_len--;
                    r.ok = 1'b1;
                    del_ok++;
                end else begin
                    del_rej++;
                end
            end
            MODE_LOCATE: begin
                // first match among held entries only
                for (k = 0; k < list_len && !r.ok; k++) begin
                    if (list_vals[k] == w.value) begin
                        r.found_at = POS_W'(k + 1);
                        r.ok = 1'b1;
                    end
                end
                if (r.ok) loc_hit++;
                else loc_miss++;
            end
            default: begin
                unused_words++;
            end
        endcase
        if (list_len > peak_len) peak_len = list_len;
        r.count_now = POS_W'(list_len);
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_round || r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        // a small pool keeps locate hits and duplicates frequent
        if (r < 50) return VAL_W'($urandom_range(0, 7)) - 16'sd4;
        if (r < 55) return 16'sh8000;
        if (r < 60) return 16'sh7fff;
        return VAL_W'($urandom());
    endfunction

    function automatic void add_op(input logic [MODE_W-1:0] mode, input int pos,
                                   input logic signed [VAL_W-1:0] v, input bit drain);
        t_list_op w;
        w.mode = mode;
        w.position = POS_W'(pos);
        w.value = v;
        w.gap = pick_gap();
        w.drain_first = drain;
        ops_to_send.push_back(w);
        if (mode == MODE_INSERT && pos >= 1 && pos <= gen_len + 1 && gen_len < DEPTH)
            gen_len++;
        else if (mode == MODE_DELETE && pos >= 1 && pos <= gen_len)
            gen_len--;
        if (mode != MODE_UNUSED) gen_words++;
    endfunction

    function automatic int pick_pos(input int hi);
        int r;
        r = $urandom_range(0, 3);
        if (hi < 1) return 1;
        if (r == 0) return 1;
        if (r == 1) return hi;
        return $urandom_range(1, hi);
    endfunction

    // one random word; grow_pct is the share of inserts among list edits
    function automatic void add_random_op(input int grow_pct, input bit drain);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            add_op(MODE_W'($urandom_range(0, 3)), $urandom_range(0, 127),
                   VAL_W'($urandom()), drain);
        end else if (r < 22) begin
            add_op(MODE_LOCATE, $urandom_range(0, 127), pick_value(), drain);
        end else if ($urandom_range(0, 99) < grow_pct) begin
            add_op(MODE_INSERT, pick_pos(gen_len + 1), pick_value(), drain);
        end else begin
            add_op(MODE_DELETE, pick_pos(gen_len), pick_value(), drain);
        end
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                list_results_due.push_back(apply_list_op(op_on_bus));
                words_sent++;
            end
            if (!i_valid || o_ready) begin
                if (ops_to_send.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (ops_to_send[0].gap > 0) begin
                    ops_to_send[0].gap--;
                    i_valid <= 1'b0;
                end else if (ops_to_send[0].drain_first && list_results_due.size() != 0) begin
                    i_valid <= 1'b0;
                end else begin
                    op_on_bus = ops_to_send.pop_front();
                    i_mode     <= op_on_bus.mode;
                    i_position <= op_on_bus.position;
                    i_value    <= op_on_bus.value;
                    i_valid    <= 1'b1;
                end
            end
        end
    end

    // monitor and receiver stalls
    int stall_left = 0;
    int steady_left = 0;

    always @(posedge i_clk) begin
        t_list_result want;
        int r;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                words_checked++;
                if (list_results_due.size() == 0) begin
                    flag_mismatch("result word with nothing outstanding");
                end else begin
                    want = list_results_due.pop_front();
                    if (o_ok !== want.ok)
                        flag_mismatch($sformatf("word %0d ok %b, want %b",
                                      words_checked, o_ok, want.ok));
                    if (o_found_at !== want.found_at)
                        flag_mismatch($sformatf("word %0d found_at %0d, want %0d",
                                      words_checked, o_found_at, want.found_at));
                    if (o_count_now !== want.count_now)
                        flag_mismatch($sformatf("word %0d count_now %0d, want %0d",
                                      words_checked, o_count_now, want.count_now));
                end
            end
            r = $urandom_range(0, 99);
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if (steady_left > 0) begin
                steady_left--;
                i_ready <= 1'b1;
            end else if (r < 3) begin
                steady_left = $urandom_range(40, 200);
                i_ready <= 1'b1;
            end else if (r < 70) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b0;
                stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(5, 40);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int guard;
        int round_kind;
        int round_no;
        int j;

        // directed: empty list, bounds, extremes, duplicates, unused mode
        add_op(MODE_LOCATE, 0, 16'sh0000, 1'b0);
        add_op(MODE_DELETE, 1, 16'sh0000, 1'b0);
        add_op(MODE_INSERT, 0, 16'sh0001, 1'b0);
        add_op(MODE_INSERT, 2, 16'sh0001, 1'b0);
        add_op(MODE_INSERT, 1, 16'sh8000, 1'b0);
        add_op(MODE_INSERT, 2, 16'sh7fff, 1'b0);
        add_op(MODE_INSERT, 1, 16'sh0000, 1'b0);
        add_op(MODE_INSERT, 2, -16'sd1, 1'b0);
        add_op(MODE_INSERT, 127, 16'sh5555, 1'b0);
        add_op(MODE_INSERT, 3, 16'sd7, 1'b0);
        add_op(MODE_INSERT, 6, 16'sd7, 1'b0);
        add_op(MODE_LOCATE, 0, 16'sh7fff, 1'b0);
        add_op(MODE_LOCATE, 127, 16'sh8000, 1'b0);
        add_op(MODE_LOCATE, 1, 16'sd7, 1'b0);
        add_op(MODE_LOCATE, 1, 16'sh2aaa, 1'b0);
        add_op(MODE_UNUSED, 1, 16'sd7, 1'b0);
        add_op(MODE_UNUSED, 127, 16'shffff, 1'b0);
        add_op(MODE_DELETE, 7, 16'sh0000, 1'b0);
        add_op(MODE_DELETE, 0, 16'sh0000, 1'b0);
        add_op(MODE_DELETE, 6, 16'sh0000, 1'b0);
        add_op(MODE_DELETE, 1, 16'sh0000, 1'b0);
        add_op(MODE_LOCATE, 1, 16'sd7, 1'b0);
        add_op(MODE_DELETE, 2, 16'sh0000, 1'b0);
        add_op(MODE_LOCATE, 1, 16'sh7fff, 1'b0);

        // random rounds: fill to full, drain to empty, or a mixed stretch
        round_no = 0;
        while (gen_words < TARGET_WORDS) begin
            round_kind = (round_no < 2) ? round_no : $urandom_range(0, 2);
            quiet_round = ($urandom_range(0, 3) == 0);
            add_random_op(50, round_no == 1 || $urandom_range(0, 2) == 0);
            if (round_kind == 0) begin
                while (gen_len < DEPTH) add_random_op(85, 1'b0);
                for (j = 0; j < 4; j++) add_op(MODE_INSERT, pick_pos(DEPTH + 1),
                                               pick_value(), 1'b0);
            end else if (round_kind == 1) begin
                while (gen_len > 0) add_random_op(15, 1'b0);
                for (j = 0; j < 3; j++) add_op(MODE_DELETE, $urandom_range(0, 2),
                                               pick_value(), 1'b0);
            end else begin
                for (j = $urandom_range(20, 60); j > 0; j--) add_random_op(50, 1'b0);
            end
            round_no++;
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (ops_to_send.size() != 0 || i_valid) @(posedge i_clk);
        guard = 0;
        while (list_results_due.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (10) @(posedge i_clk);
        if (list_results_due.size() != 0)
            flag_mismatch($sformatf("%0d result words never arrived",
                          list_results_due.size()));

        $display("Covered %0d words: %0d/%0d inserts ok/rejected (%0d on a full list),",
                 words_sent, ins_ok, ins_rej, full_rej);
        $display("%0d/%0d deletes ok/rejected, %0d/%0d locate hits/misses, %0d unused, peak %0d",
                 del_ok, del_rej, loc_hit, loc_miss, unused_words, peak_len);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
